// File: rtl/core/pidaw_pkg.sv
`default_nettype none
package pidaw_pkg;

  // datapath operation codes
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_CLEAR  = 4'd2;
  localparam logic [3:0] OP_MUL_P  = 4'd3;
  localparam logic [3:0] OP_MUL_I  = 4'd4;
  localparam logic [3:0] OP_MUL_D  = 4'd5;
  localparam logic [3:0] OP_INTEG  = 4'd6;
  localparam logic [3:0] OP_MUL_K  = 4'd7;
  localparam logic [3:0] OP_KTERM  = 4'd8;
  localparam logic [3:0] OP_DIV    = 4'd9;
  localparam logic [3:0] OP_FINISH = 4'd10;
  localparam logic [3:0] OP_ZERO   = 4'd11;

  // register indexes
  localparam logic [2:0] REG_KP   = 3'd0;
  localparam logic [2:0] REG_KI   = 3'd1;
  localparam logic [2:0] REG_KD   = 3'd2;
  localparam logic [2:0] REG_BND  = 3'd3;
  localparam logic [2:0] REG_DMIN = 3'd4;
  localparam logic [2:0] REG_DMAX = 3'd5;

  localparam int DivSteps = 64;

  typedef struct packed {
    logic signed [31:0] gain_proportional;
    logic signed [31:0] gain_integral;
    logic signed [31:0] gain_derivative;
    logic [30:0]        integral_bound;
    logic signed [31:0] drive_minimum;
    logic signed [31:0] drive_maximum;
  } cfg_t;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic has_history;
  } stat_t;

  // apply sign to a magnitude, saturating to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic neg, input logic [63:0] mag);
    logic signed [31:0] r;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) r = 32'sh8000_0000;
      else r = -$signed(mag[31:0]);
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else r = $signed(mag[31:0]);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/pidaw_if.sv
`default_nettype none
interface pidaw_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] setpoint;
  logic signed [31:0] measured;
  logic [31:0]        time_step;
  modport source (output valid, command, setpoint, measured, time_step, input ready);
  modport sink (input valid, command, setpoint, measured, time_step, output ready);
endinterface

interface pidaw_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive_value;
  logic               above_max;
  logic               below_min;
  logic               integral_held;
  modport source (output valid, drive_value, above_max, below_min, integral_held,
                  input ready);
  modport sink (input valid, drive_value, above_max, below_min, integral_held,
                output ready);
endinterface
`default_nettype wire

// File: rtl/core/pidaw_regs.sv
`default_nettype none
module pidaw_regs
  import pidaw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_proportional <= '0;
      cfg.gain_integral     <= '0;
      cfg.gain_derivative   <= '0;
      cfg.integral_bound    <= 31'h7FFF_FFFF;
      cfg.drive_minimum     <= 32'sh8000_0000;
      cfg.drive_maximum     <= 32'sh7FFF_FFFF;
    end else if (wr) begin
      case (idx)
        REG_KP:   cfg.gain_proportional <= pwdata;
        REG_KI:   cfg.gain_integral     <= pwdata;
        REG_KD:   cfg.gain_derivative   <= pwdata;
        REG_BND:  cfg.integral_bound    <= pwdata[30:0];
        REG_DMIN: cfg.drive_minimum     <= pwdata;
        REG_DMAX: cfg.drive_maximum     <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_KP:   prdata = cfg.gain_proportional;
      REG_KI:   prdata = cfg.gain_integral;
      REG_KD:   prdata = cfg.gain_derivative;
      REG_BND:  prdata = {1'b0, cfg.integral_bound};
      REG_DMIN: prdata = cfg.drive_minimum;
      REG_DMAX: prdata = cfg.drive_maximum;
      default:  prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/pidaw_ctrl.sv
`default_nettype none
module pidaw_ctrl
  import pidaw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_clear,
  input  wire logic in_dt_zero,
  input  wire logic out_ready,
  input  stat_t     stat,
  output logic      in_ready,
  output logic      out_valid,
  output cmd_t      cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MP   = 4'd1;
  localparam logic [3:0] S_MI   = 4'd2;
  localparam logic [3:0] S_MD   = 4'd3;
  localparam logic [3:0] S_INT  = 4'd4;
  localparam logic [3:0] S_MK   = 4'd5;
  localparam logic [3:0] S_KT   = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state, state_next;
  logic [5:0] count;
  logic       zero_step;
  logic       out_free;
  logic       fin_go;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign fin_go   = (state == S_FIN) && out_free;

  // next state and datapath command
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_clear) cmd.op = OP_CLEAR;
          else begin
            cmd.op     = OP_LOAD;
            state_next = in_dt_zero ? S_FIN : S_MP;
          end
        end
      end
      S_MP: begin cmd.op = OP_MUL_P; state_next = S_MI; end
      S_MI: begin cmd.op = OP_MUL_I; state_next = S_MD; end
      S_MD: begin cmd.op = OP_MUL_D; state_next = S_INT; end
      S_INT: begin cmd.op = OP_INTEG; state_next = S_MK; end
      S_MK: begin cmd.op = OP_MUL_K; state_next = S_KT; end
      S_KT: begin
        cmd.op     = OP_KTERM;
        state_next = stat.has_history ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (count == 6'(DivSteps - 1)) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.op     = zero_step ? OP_ZERO : OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state, step counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      zero_step <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) count <= count + 6'd1;
      else count <= '0;
      if (state == S_IDLE && in_valid) zero_step <= in_dt_zero;
      if (fin_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/pidaw_datapath.sv
`default_nettype none
module pidaw_datapath
  import pidaw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  cmd_t                    cmd,
  input  cfg_t                    cfg,
  input  wire logic signed [31:0] setpoint,
  input  wire logic signed [31:0] measured,
  input  wire logic [31:0]        time_step,
  output stat_t                   stat,
  output logic signed [31:0]      drive_value,
  output logic                    above_max,
  output logic                    below_min,
  output logic                    integral_held
);

  // controller state
  logic signed [31:0] integral_sum;
  logic signed [32:0] previous_error;
  logic               has_history;

  // working registers
  logic signed [32:0] err;
  logic [31:0]        dt;
  logic [65:0]        prod;
  logic               mneg;
  logic               dneg;
  logic signed [31:0] prop, step, kterm, integ;
  logic [31:0]        rem;
  logic [63:0]        quo;

  logic [33:0]        mul_a, mul_a_next;
  logic [31:0]        mul_b, mul_b_next;
  logic               mneg_next;
  logic signed [33:0] diff;
  logic [33:0]        diff_mag;
  logic [32:0]        err_mag;
  logic [31:0]        kp_mag, ki_mag, kd_mag;
  logic [30:0]        integ_mag;
  logic signed [31:0] prod_sat;
  logic signed [32:0] cand;
  logic signed [32:0] bnd;
  logic signed [31:0] integ_next;
  logic [32:0]        trial;
  logic               fits;
  logic signed [31:0] deriv;
  logic signed [34:0] total;
  logic               hi, lo, keep;

  assign stat.has_history = has_history;

  // magnitudes of the operands
  assign err_mag   = err[32] ? 33'(-err) : 33'(err);
  assign diff      = 34'(err) - 34'(previous_error);
  assign diff_mag  = diff[33] ? 34'(-diff) : 34'(diff);
  assign kp_mag    = cfg.gain_proportional[31] ? 32'(-cfg.gain_proportional)
                                               : 32'(cfg.gain_proportional);
  assign ki_mag    = cfg.gain_integral[31] ? 32'(-cfg.gain_integral) : 32'(cfg.gain_integral);
  assign kd_mag    = cfg.gain_derivative[31] ? 32'(-cfg.gain_derivative)
                                             : 32'(cfg.gain_derivative);
  assign integ_mag = integ[31] ? 31'(-integ) : integ[30:0];
  assign prod_sat  = sat32(mneg, {14'd0, prod[65:16]});

  // shared multiplier operand select
  always_comb begin
    mul_a_next = '0;
    mul_b_next = '0;
    mneg_next  = 1'b0;
    case (cmd.op)
      OP_MUL_P: begin
        mul_a_next = {1'b0, err_mag};
        mul_b_next = kp_mag;
        mneg_next  = err[32] != cfg.gain_proportional[31];
      end
      OP_MUL_I: begin
        mul_a_next = {1'b0, err_mag};
        mul_b_next = dt;
        mneg_next  = err[32];
      end
      OP_MUL_D: begin
        mul_a_next = diff_mag;
        mul_b_next = kd_mag;
        mneg_next  = diff[33] != cfg.gain_derivative[31];
      end
      OP_MUL_K: begin
        mul_a_next = {3'd0, integ_mag};
        mul_b_next = ki_mag;
        mneg_next  = integ[31] != cfg.gain_integral[31];
      end
      default: ;
    endcase
  end

  assign mul_a = mul_a_next;
  assign mul_b = mul_b_next;

  // integral candidate and clamp
  assign cand = 33'(integral_sum) + 33'(step);
  assign bnd  = $signed({2'b00, cfg.integral_bound});
  always_comb begin
    if (cand > bnd) integ_next = 32'(bnd);
    else if (cand < -bnd) integ_next = 32'(-bnd);
    else integ_next = 32'(cand);
  end

  // restoring divider step
  assign trial = {rem, quo[63]};
  assign fits  = trial >= {1'b0, dt};

  // output sum, clamp and anti-windup decision
  assign deriv = has_history ? sat32(dneg, quo) : 32'sd0;
  assign total = 35'(prop) + 35'(kterm) + 35'(deriv);
  assign hi    = total > 35'(cfg.drive_maximum);
  assign lo    = total < 35'(cfg.drive_minimum);
  assign keep  = (!hi && !lo) || (hi && err[32]) || (lo && !err[32] && err != '0);

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        err <= 33'(setpoint) - 33'(measured);
        dt  <= time_step;
      end
      OP_MUL_I: prop <= prod_sat;
      OP_MUL_D: step <= prod_sat;
      OP_INTEG: begin
        integ <= integ_next;
        dneg  <= mneg;
        rem   <= '0;
        quo   <= prod[63:0];
      end
      OP_KTERM: kterm <= prod_sat;
      OP_DIV: begin
        rem <= fits ? 32'(trial - {1'b0, dt}) : trial[31:0];
        quo <= {quo[62:0], fits};
      end
      default: ;
    endcase
    prod <= mul_a * mul_b;
    mneg <= mneg_next;
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      drive_value   <= hi ? cfg.drive_maximum : (lo ? cfg.drive_minimum : 32'(total));
      above_max     <= hi;
      below_min     <= lo;
      integral_held <= !keep;
    end else if (cmd.op == OP_ZERO) begin
      drive_value   <= '0;
      above_max     <= 1'b0;
      below_min     <= 1'b0;
      integral_held <= 1'b0;
    end
  end

  // controller state update
  always_ff @(posedge clk) begin
    if (rst || cmd.op == OP_CLEAR) begin
      integral_sum   <= '0;
      previous_error <= '0;
      has_history    <= 1'b0;
    end else if (cmd.op == OP_FINISH) begin
      if (keep) integral_sum <= integ;
      previous_error <= err;
      has_history    <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/pid_controller_anti_windup_top.sv
// update: after accept, states MP, MI, MD, INT, MK and KT run, then, with history only,
// the derivative divider at one quotient bit per cycle, then FIN; a zero time step goes
// straight to FIN; no new item is accepted until FIN returns to idle; clear items give
// no result; a result still waiting on the output holds the final step
// reset: synchronous active-high rst zeroes the integral, previous error and history,
// and loads the register defaults
`default_nettype none
module pid_controller_anti_windup_top
  import pidaw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  pidaw_in_if.sink         in_ch,
  pidaw_out_if.source      out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  pidaw_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  pidaw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_clear(in_ch.command),
    .in_dt_zero(in_ch.time_step == '0), .out_ready(out_ch.ready), .stat(stat),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .cmd(cmd)
  );

  pidaw_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .cfg(cfg), .setpoint(in_ch.setpoint),
    .measured(in_ch.measured), .time_step(in_ch.time_step), .stat(stat),
    .drive_value(out_ch.drive_value), .above_max(out_ch.above_max),
    .below_min(out_ch.below_min), .integral_held(out_ch.integral_held)
  );

`ifndef SYNTHESIS
  // a held integral only happens while saturated
  a_held_sat: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.integral_held |-> out_ch.above_max || out_ch.below_min)
    else $error("integral held without saturation");

  // a clear transaction keeps the block idle
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready && in_ch.command |=> in_ch.ready)
    else $error("clear left the idle state");

  // high saturation drives the maximum
  a_sat_hi: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.above_max && $stable(cfg.drive_maximum)
    |-> out_ch.drive_value == cfg.drive_maximum)
    else $error("saturated high output differs from maximum");
`endif

endmodule
`default_nettype wire
